### design/fixed_capacity_multiset_core_assert.svh
// Assertion macros used by the multiset core.
// Each macro takes a label, the clock, the active-low reset and two conditions.
`ifndef FIXED_CAPACITY_MULTISET_CORE_ASSERT_SVH
`define FIXED_CAPACITY_MULTISET_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multiset assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("multiset assertion failed");

`endif

### design/fcm_pkg.sv
`default_nettype none

package fcm_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int DATA_W   = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ANSWER_W = 16;
    localparam int FILL_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_ERASE_ALL = 3'd1,
        OP_ERASE_ONE = 3'd2,
        OP_COUNT     = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

### design/fcm_req_if.sv
`default_nettype none

interface fcm_req_if;
    logic                             valid;
    logic                             ready;
    logic [fcm_pkg::OP_W-1:0]         operation;
    logic [fcm_pkg::DATA_W-1:0]       value;
    logic [fcm_pkg::POS_W-1:0]        position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink (input valid, input operation, input value, input position,
                  output ready);
endinterface

`default_nettype wire

### design/fcm_rsp_if.sv
`default_nettype none

interface fcm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [fcm_pkg::STATUS_W-1:0]     status;
    logic [fcm_pkg::ANSWER_W-1:0]     answer;
    logic [fcm_pkg::FILL_W-1:0]       fill;

    modport source (output valid, output status, output answer, output fill,
                    input ready);
    modport sink (input valid, input status, input answer, input fill,
                  output ready);
endinterface

`default_nettype wire

### design/fixed_capacity_multiset_core.sv
// Channel  Dir  Fields                              Accepted when
// req      in   operation[3], value[16], position[5]  req.valid && req.ready
// rsp      out  status[2], answer[16], fill[6]        rsp.valid && rsp.ready
//
// Insert, read and unused codes load their result once the result register is free,
// and the input is ready again from then on; no new item is taken before that.
// Count and both erase operations walk the stored entries with one comparator, one
// entry or one removal per cycle while the result register is free, then load the
// result when the walk reaches the fill. Erase one stops early at its first match.
// Reset clears the fill count and the control state; the entry memory is not cleared.
// While a result waits for the receiver, the item in progress holds at its current step.
`default_nettype none

`include "fixed_capacity_multiset_core_assert.svh"

module fixed_capacity_multiset_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fcm_req_if.sink      req,
    fcm_rsp_if.source    rsp
);

    localparam int IW = fcm_pkg::IDX_W;
    localparam int CW = fcm_pkg::CNT_W;
    localparam int VW = fcm_pkg::VALUE_BITS;

    // The entry store: one write port and two registered read ports. Port A
    // follows the scan index, or the position for a read; port B always points
    // at the last stored element, which is what fills a hole left by an erase.
    logic [VW-1:0] mem [fcm_pkg::CAPACITY];

    fcm_pkg::state_t state_reg, state_next;

    logic [fcm_pkg::OP_W-1:0]   op_reg;
    logic [VW-1:0]              val_reg;
    logic [fcm_pkg::POS_W-1:0]  pos_reg;

    // The scan index may reach the fill count, so it carries one extra bit.
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] hits_reg, hits_next;
    logic [CW-1:0] last_next;

    logic                          ov_reg, ov_next;
    fcm_pkg::status_t              st_reg, st_next;
    logic [fcm_pkg::ANSWER_W-1:0]  ans_reg, ans_next;
    logic [fcm_pkg::FILL_W-1:0]    fill_reg, fill_next;

    logic          we;
    logic [IW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [IW-1:0] addr_a;
    logic [IW-1:0] addr_b;
    logic [VW-1:0] rd_a_reg;
    logic [VW-1:0] rd_b_reg;

    logic out_free;
    logic hit;
    logic scan_end;

    assign req.ready  = (state_reg == fcm_pkg::S_IDLE);
    assign rsp.valid  = ov_reg;
    assign rsp.status = st_reg;
    assign rsp.answer = ans_reg;
    assign rsp.fill   = fill_reg;

    // The result register is free once its current item leaves.
    assign out_free = !ov_reg || rsp.ready;
    assign hit      = (rd_a_reg == val_reg);
    assign scan_end = (idx_reg >= occ_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        occ_next   = occ_reg;
        hits_next  = hits_reg;
        ov_next    = ov_reg && !rsp.ready;
        st_next    = st_reg;
        ans_next   = ans_reg;
        fill_next  = fill_reg;
        we         = 1'b0;
        waddr      = idx_reg[IW-1:0];
        wdata      = rd_b_reg;
        last_next  = occ_reg - CW'(1);
        addr_a     = idx_reg[IW-1:0];
        addr_b     = last_next[IW-1:0];

        case (state_reg)
            fcm_pkg::S_IDLE:
            begin
                if (req.operation == fcm_pkg::OP_READ)
                begin
                    addr_a = req.position[IW-1:0];
                end
                else
                begin
                    addr_a = '0;
                end
                if (req.valid)
                begin
                    idx_next   = '0;
                    hits_next  = '0;
                    state_next = fcm_pkg::S_EXEC;
                end
            end

            fcm_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    case (op_reg)
                        fcm_pkg::OP_INSERT:
                        begin
                            if (occ_reg >= CW'(fcm_pkg::CAPACITY))
                            begin
                                st_next = fcm_pkg::STAT_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = occ_reg[IW-1:0];
                                wdata    = val_reg;
                                occ_next = occ_reg + CW'(1);
                                st_next  = fcm_pkg::STAT_OK;
                            end
                            ans_next   = '0;
                            ov_next    = 1'b1;
                            state_next = fcm_pkg::S_IDLE;
                        end

                        fcm_pkg::OP_READ:
                        begin
                            if (CW'(pos_reg) >= occ_reg)
                            begin
                                st_next  = fcm_pkg::STAT_RANGE;
                                ans_next = '0;
                            end
                            else
                            begin
                                st_next  = fcm_pkg::STAT_OK;
                                ans_next = fcm_pkg::ANSWER_W'(rd_a_reg);
                            end
                            ov_next    = 1'b1;
                            state_next = fcm_pkg::S_IDLE;
                        end

                        fcm_pkg::OP_ERASE_ALL, fcm_pkg::OP_ERASE_ONE, fcm_pkg::OP_COUNT:
                        begin
                            if (scan_end)
                            begin
                                if (op_reg == fcm_pkg::OP_ERASE_ONE)
                                begin
                                    st_next  = fcm_pkg::STAT_ABSENT;
                                    ans_next = '0;
                                end
                                else
                                begin
                                    st_next  = fcm_pkg::STAT_OK;
                                    ans_next = fcm_pkg::ANSWER_W'(hits_reg);
                                end
                                ov_next    = 1'b1;
                                state_next = fcm_pkg::S_IDLE;
                            end
                            else if (!hit)
                            begin
                                idx_next = idx_reg + CW'(1);
                            end
                            else if (op_reg == fcm_pkg::OP_COUNT)
                            begin
                                hits_next = hits_reg + CW'(1);
                                idx_next  = idx_reg + CW'(1);
                            end
                            else
                            begin
                                // Fill the hole from the last element and check
                                // the same slot again on the next cycle.
                                we        = 1'b1;
                                occ_next  = occ_reg - CW'(1);
                                hits_next = hits_reg + CW'(1);
                                if (op_reg == fcm_pkg::OP_ERASE_ONE)
                                begin
                                    st_next    = fcm_pkg::STAT_OK;
                                    ans_next   = fcm_pkg::ANSWER_W'(1);
                                    ov_next    = 1'b1;
                                    state_next = fcm_pkg::S_IDLE;
                                end
                            end
                        end

                        default:
                        begin
                            st_next    = fcm_pkg::STAT_OK;
                            ans_next   = '0;
                            ov_next    = 1'b1;
                            state_next = fcm_pkg::S_IDLE;
                        end
                    endcase
                    fill_next = fcm_pkg::FILL_W'(occ_next);
                end
                last_next = occ_next - CW'(1);
                if (op_reg == fcm_pkg::OP_READ)
                begin
                    // A read keeps pointing at its entry while its result waits.
                    addr_a = pos_reg[IW-1:0];
                end
                else
                begin
                    addr_a = idx_next[IW-1:0];
                end
                addr_b = last_next[IW-1:0];
            end

            default:
            begin
                state_next = fcm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcm_pkg::S_IDLE;
            occ_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.operation;
            val_reg <= VW'(req.value);
            pos_reg <= req.position;
        end
        idx_reg  <= idx_next;
        hits_reg <= hits_next;
        st_reg   <= st_next;
        ans_reg  <= ans_next;
        fill_reg <= fill_next;
    end

    // Reads see a write to the same address in the same cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= (we && (waddr == addr_a)) ? wdata : mem[addr_a];
        rd_b_reg <= (we && (waddr == addr_b)) ? wdata : mem[addr_b];
    end

    `FCM_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= CW'(fcm_pkg::CAPACITY))
    `FCM_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_reg == fcm_pkg::S_IDLE, !we)
    `FCM_ASSERT_NOW(a_idx_bound, clk, rst_n, state_reg == fcm_pkg::S_EXEC, idx_reg <= occ_reg)
    `FCM_ASSERT_NEXT(a_erase_shrinks, clk, rst_n,
        we && (op_reg != fcm_pkg::OP_INSERT), occ_reg == $past(occ_reg) - CW'(1))
    `FCM_ASSERT_NEXT(a_full_fill, clk, rst_n,
        ov_next && !(ov_reg && !rsp.ready) && (st_next == fcm_pkg::STAT_FULL),
        fill_reg == fcm_pkg::FILL_W'(fcm_pkg::CAPACITY))

endmodule

`default_nettype wire

### tb/tb_fixed_capacity_multiset_core.sv
`timescale 1ns / 100ps

module tb_fixed_capacity_multiset_core;

    // Cycles in a row without any accepted item before the run is declared hung.
    // The slowest item walks every stored entry, and stalls at two in three are short.
    localparam int QUIET_LIMIT = 4000;

    // Operation codes that the block must treat as a no-op.
    localparam logic [fcm_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [fcm_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [fcm_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam int PHASE_ITEMS = 360;
    localparam int POOL_SIZE   = 4;

    typedef struct packed {
        logic [fcm_pkg::STATUS_W-1:0] status;
        logic [fcm_pkg::ANSWER_W-1:0] answer;
        logic [fcm_pkg::FILL_W-1:0]   fill;
    } reply_t;

    // Mirror of the bag contents. Every accepted item is applied here, and the
    // reply it must produce is queued until the block hands that reply out.
    class bag_mirror;
        logic [fcm_pkg::VALUE_BITS-1:0] slots [fcm_pkg::CAPACITY];
        int unsigned                    stored;
        reply_t                         pending_replies [$];
        int unsigned                    failures;

        function void apply_request(logic [fcm_pkg::OP_W-1:0] op,
                                    logic [fcm_pkg::DATA_W-1:0] val,
                                    logic [fcm_pkg::POS_W-1:0] pos);
            reply_t      r;
            int unsigned idx;
            int unsigned hits;
            bit          hit;
            r.status = fcm_pkg::STAT_OK;
            r.answer = '0;
            hits     = 0;
            hit      = 1'b0;
            case (op)
                fcm_pkg::OP_INSERT:
                begin
                    if (stored >= fcm_pkg::CAPACITY)
                        r.status = fcm_pkg::STAT_FULL;
                    else
                    begin
                        slots[stored] = val;
                        stored++;
                    end
                end
                fcm_pkg::OP_ERASE_ALL:
                begin
                    // The hole is refilled from the tail, so the same slot is
                    // looked at again before moving on.
                    idx = 0;
                    while (idx < stored)
                    begin
                        if (slots[idx] == val)
                        begin
                            stored--;
                            slots[idx] = slots[stored];
                            hits++;
                        end
                        else
                            idx++;
                    end
                    r.answer = fcm_pkg::ANSWER_W'(hits);
                end
                fcm_pkg::OP_ERASE_ONE:
                begin
                    for (idx = 0; idx < stored && !hit; idx++)
                    begin
                        if (slots[idx] == val)
                        begin
                            stored--;
                            slots[idx] = slots[stored];
                            hit = 1'b1;
                        end
                    end
                    r.status = hit ? fcm_pkg::STAT_OK : fcm_pkg::STAT_ABSENT;
                    r.answer = hit ? fcm_pkg::ANSWER_W'(1) : '0;
                end
                fcm_pkg::OP_COUNT:
                begin
                    for (idx = 0; idx < stored; idx++)
                        if (slots[idx] == val)
                            hits++;
                    r.answer = fcm_pkg::ANSWER_W'(hits);
                end
                fcm_pkg::OP_READ:
                begin
                    if (pos >= stored)
                        r.status = fcm_pkg::STAT_RANGE;
                    else
                        r.answer = slots[pos];
                end
                default:
                begin
                end
            endcase
            r.fill = fcm_pkg::FILL_W'(stored);
            pending_replies.push_back(r);
        endfunction

        function void report(string what, reply_t want, reply_t got);
            failures++;
            if (failures <= 10)
                $display("%0t: %s: expected status %0d answer %h fill %0d, %s %0d %s %h %s %0d",
                         $time, what, want.status, want.answer, want.fill,
                         "got status", got.status, "answer", got.answer,
                         "fill", got.fill);
        endfunction

        function void match_response(logic [fcm_pkg::STATUS_W-1:0] st,
                                     logic [fcm_pkg::ANSWER_W-1:0] ans,
                                     logic [fcm_pkg::FILL_W-1:0] fl);
            reply_t want;
            reply_t got;
            got.status = st;
            got.answer = ans;
            got.fill   = fl;
            if (pending_replies.size() == 0)
            begin
                want = '0;
                report("result with nothing outstanding", want, got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report("status mismatch", want, got);
                else if (got.answer !== want.answer)
                    report("answer mismatch", want, got);
                else if (got.fill !== want.fill)
                    report("fill mismatch", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fcm_req_if req_ch ();
    fcm_rsp_if rsp_ch ();

    fixed_capacity_multiset_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bag_mirror                  board;
    int                         tx_idle_pct;
    int                         rx_stall_pct;
    int                         quiet_cycles;
    logic [fcm_pkg::DATA_W-1:0] value_pool [POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver drops ready at random, at a rate set per phase.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Results are sampled at the edge that accepts them. The same process keeps
    // the watchdog, which only counts cycles where no item moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                board.match_response(rsp_ch.status, rsp_ch.answer, rsp_ch.fill);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("tb_fixed_capacity_multiset_core failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, with random idle cycles in front of it, and returns at
    // the edge where it is accepted. Valid stays high into the next item unless
    // that item starts with an idle cycle.
    task automatic send_item(input logic [fcm_pkg::OP_W-1:0] op,
                             input logic [fcm_pkg::DATA_W-1:0] val,
                             input logic [fcm_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        req_ch.position  <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.apply_request(op, val, pos);
    endtask

    // Picks one random item. Values are mostly drawn from what is already
    // stored or from a small pool, so that duplicates, hits and erasures are
    // frequent; the rest are arbitrary 16-bit values.
    task automatic send_random(input int insert_pct);
        logic [fcm_pkg::OP_W-1:0]   op;
        logic [fcm_pkg::DATA_W-1:0] val;
        logic [fcm_pkg::POS_W-1:0]  pos;
        int                         roll;
        roll = $urandom_range(99);
        if (roll < insert_pct)
            op = fcm_pkg::OP_INSERT;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 18)
                op = fcm_pkg::OP_ERASE_ALL;
            else if (roll < 45)
                op = fcm_pkg::OP_ERASE_ONE;
            else if (roll < 68)
                op = fcm_pkg::OP_COUNT;
            else if (roll < 95)
                op = fcm_pkg::OP_READ;
            else
                op = fcm_pkg::OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        roll = $urandom_range(99);
        if (roll < 15)
            val = fcm_pkg::DATA_W'($urandom());
        else if (roll < 60 && board.stored != 0)
            val = board.slots[$urandom_range(board.stored - 1)];
        else
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
        if (board.stored != 0 && $urandom_range(99) < 75)
            pos = fcm_pkg::POS_W'($urandom_range(board.stored - 1));
        else
            pos = fcm_pkg::POS_W'($urandom());
        send_item(op, val, pos);
    endtask

    initial
    begin
        int insert_pct;
        board        = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        quiet_cycles = 0;
        insert_pct   = 50;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= fcm_pkg::OP_INSERT;
        req_ch.value     <= '0;
        req_ch.position  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items on an empty bag: out-of-range read, erase one of an
        // absent value, erase all with no match, and a zero count.
        send_item(fcm_pkg::OP_READ, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_ERASE_ONE, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_ERASE_ALL, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_COUNT, 16'h0000, 5'd0);

        // Extreme values with duplicates, then counts and reads around the fill.
        send_item(fcm_pkg::OP_INSERT, 16'hFFFF, 5'd31);
        send_item(fcm_pkg::OP_INSERT, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_INSERT, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_INSERT, 16'h5A5A, 5'd0);
        send_item(fcm_pkg::OP_INSERT, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_COUNT, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_READ, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_READ, 16'hFFFF, 5'd4);
        send_item(fcm_pkg::OP_READ, 16'h0000, 5'd5);
        send_item(fcm_pkg::OP_READ, 16'h0000, 5'd31);

        // Erasing the first copy pulls the tail entry into slot zero.
        send_item(fcm_pkg::OP_ERASE_ONE, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_READ, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_ERASE_ALL, 16'hFFFF, 5'd0);
        send_item(fcm_pkg::OP_ERASE_ONE, 16'h1234, 5'd0);
        send_item(OP_SPARE_LO, 16'hFFFF, 5'd31);
        send_item(OP_SPARE_MID, 16'hA5A5, 5'd10);
        send_item(OP_SPARE_HI, 16'h0000, 5'd0);
        send_item(fcm_pkg::OP_COUNT, 16'h0000, 5'd0);

        // Random phases: no idling, sender idling, receiver stalling, then both.
        // Within a phase the insert rate swings between filling the bag up to
        // full and draining it.
        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 34 : 0;
            rx_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 34 : 0;
            for (int k = 0; k < POOL_SIZE; k++)
                value_pool[k] = fcm_pkg::DATA_W'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 45 == 0)
                    case ($urandom_range(2))
                        0:       insert_pct = 80;
                        1:       insert_pct = 40;
                        default: insert_pct = 10;
                    endcase
                send_random(insert_pct);
            end
        end

        req_ch.valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (fcm_pkg::CAPACITY + 8) @(posedge clk);

        if (board.failures == 0)
            $display("tb_fixed_capacity_multiset_core passed");
        else
            $display("tb_fixed_capacity_multiset_core failed");
        $finish;
    end

endmodule
